// File: rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg: shared definitions for the table linear interpolator
// Widths, function and status codes, and the command and status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

   // table geometry
   localparam int MAX_POINTS = 2048;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // field widths
   localparam int FUNC_W = 2;
   localparam int E_W    = 24;
   localparam int V_W    = 32;
   localparam int ST_W   = 3;
   localparam int PROD_W = E_W + V_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   // function codes
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_BELOW = 3'd1;
   localparam logic [ST_W-1:0] ST_ABOVE = 3'd2;
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL  = 3'd4;

   // table read address select
   localparam logic [1:0] ASEL_ZERO = 2'd0;
   localparam logic [1:0] ASEL_ONE  = 2'd1;
   localparam logic [1:0] ASEL_LAST = 2'd2;
   localparam logic [1:0] ASEL_NEXT = 2'd3;

   // result value select
   localparam logic [1:0] RSEL_ZERO = 2'd0;
   localparam logic [1:0] RSEL_LAST = 2'd1;
   localparam logic [1:0] RSEL_QUOT = 2'd2;

   typedef struct packed {
      logic             latch_req;
      logic             clear_cnt;
      logic             append;
      logic [1:0]       addr_sel;
      logic             scan_init;
      logic             scan_step;
      logic             seg_load;
      logic             mul;
      logic             div_start;
      logic             res_load;
      logic [1:0]       res_sel;
      logic [ST_W-1:0]  res_status;
      logic             out_load;
   } tli_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              cnt_zero;
      logic              cnt_one;
      logic              cnt_full;
      logic              x_ge_last;
      logic              seg_hit;
      logic              scan_end;
      logic              div_done;
      logic              out_free;
   } tli_stat_type;

endpackage

// File: rtl/tli_req_if.sv
// ----------------------------------------------------------------------------
// tli_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface tli_req_if import tli_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [E_W-1:0]    energy;
   logic [V_W-1:0]    point_value;

   modport source (output valid, output func, output energy, output point_value,
                   input ready);
   modport sink   (input valid, input func, input energy, input point_value,
                   output ready);
endinterface

// File: rtl/tli_rsp_if.sv
// ----------------------------------------------------------------------------
// tli_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tli_rsp_if import tli_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [V_W-1:0]  result_value;
   logic [ST_W-1:0] status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink   (input valid, input result_value, input status, output ready);
endinterface

// File: rtl/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/tli_div.sv
// ----------------------------------------------------------------------------
// tli_div: restoring divider
// Divides the weighted sum by the segment width, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tli_div import tli_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [E_W-1:0]   divisor,
   output logic [V_W-1:0]   quotient,
   output logic             done
);
   logic [E_W-1:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [E_W-1:0]       den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [E_W:0]         trial;
   logic                 fits;

   // one restoring step: shift in next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = DIV_CNT_W'(NUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? E_W'(trial - {1'b0, den_ff}) : trial[E_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // quotient lies between the end values, so the low word is exact
   assign quotient = quo_ff[V_W-1:0];
   assign done     = done_ff;
endmodule

// File: rtl/tli_dp.sv
// ----------------------------------------------------------------------------
// tli_dp: interpolator datapath
// Table memories, point count, segment scan registers, multipliers,
// divider and the result and output registers.
// ----------------------------------------------------------------------------
module tli_dp import tli_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tli_cmd_type       cmd,
   output tli_stat_type      stat,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [E_W-1:0]    req_energy,
   input  logic [V_W-1:0]    req_point_value,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [V_W-1:0]    rsp_result_value,
   output logic [ST_W-1:0]   rsp_status
);
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [E_W-1:0]    x_ff, x_in;
   logic [V_W-1:0]    pval_ff, pval_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [E_W-1:0]    e_prev_ff, e_prev_in;
   logic [V_W-1:0]    v_prev_ff, v_prev_in;
   logic [E_W-1:0]    e1_ff, e1_in;
   logic [V_W-1:0]    v1_ff, v1_in;
   logic [PROD_W-1:0] p0_ff, p0_in;
   logic [PROD_W-1:0] p1_ff, p1_in;
   logic [V_W-1:0]    res_val_ff, res_val_in;
   logic [ST_W-1:0]   res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [V_W-1:0]    rsp_val_ff, rsp_val_in;
   logic [ST_W-1:0]   rsp_st_ff, rsp_st_in;

   logic [CNT_W-1:0]  cnt_m1;
   logic [ADDR_W-1:0] rd_addr;
   logic [E_W-1:0]    e_rd;
   logic [V_W-1:0]    v_rd;
   logic [E_W-1:0]    hi_gap, lo_gap;
   logic [NUM_W-1:0]  num;
   logic [E_W-1:0]    den;
   logic [V_W-1:0]    quotient;
   logic              div_done;

   assign cnt_m1 = count_ff - CNT_W'(1);

   // shared read address for both stores
   always_comb begin
      case (cmd.addr_sel)
         ASEL_ONE:  rd_addr = ADDR_W'(1);
         ASEL_LAST: rd_addr = cnt_m1[ADDR_W-1:0];
         ASEL_NEXT: rd_addr = idx_ff + ADDR_W'(1);
         default:   rd_addr = '0;
      endcase
   end

   tli_ram #(.WIDTH(E_W), .DEPTH(MAX_POINTS)) u_energy_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (x_ff),
      .rd_addr (rd_addr),
      .rd_data (e_rd)
   );

   tli_ram #(.WIDTH(V_W), .DEPTH(MAX_POINTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (pval_ff),
      .rd_addr (rd_addr),
      .rd_data (v_rd)
   );

   // interpolation arithmetic
   assign hi_gap = e1_ff - x_ff;
   assign lo_gap = x_ff - e_prev_ff;
   assign num    = {1'b0, p0_ff} + {1'b0, p1_ff};
   assign den    = e1_ff - e_prev_ff;

   tli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num),
      .divisor  (den),
      .quotient (quotient),
      .done     (div_done)
   );

   // next-state logic
   always_comb begin
      func_in      = func_ff;
      x_in         = x_ff;
      pval_in      = pval_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      e_prev_in    = e_prev_ff;
      v_prev_in    = v_prev_ff;
      e1_in        = e1_ff;
      v1_in        = v1_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;

      if (cmd.latch_req) begin
         func_in = req_func;
         x_in    = req_energy;
         pval_in = req_point_value;
      end
      if (cmd.clear_cnt) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end

      // segment scan: previous entry in e_prev/v_prev, current from the RAMs
      if (cmd.scan_init) begin
         idx_in    = ADDR_W'(1);
         e_prev_in = e_rd;
         v_prev_in = v_rd;
      end else if (cmd.scan_step) begin
         idx_in    = idx_ff + ADDR_W'(1);
         e_prev_in = e_rd;
         v_prev_in = v_rd;
      end
      if (cmd.seg_load) begin
         e1_in = e_rd;
         v1_in = v_rd;
      end
      if (cmd.mul) begin
         p0_in = PROD_W'(hi_gap) * PROD_W'(v_prev_ff);
         p1_in = PROD_W'(lo_gap) * PROD_W'(v1_ff);
      end

      if (cmd.res_load) begin
         res_st_in = cmd.res_status;
         case (cmd.res_sel)
            RSEL_LAST: res_val_in = v_rd;
            RSEL_QUOT: res_val_in = quotient;
            default:   res_val_in = '0;
         endcase
      end

      // output register
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = res_val_ff;
         rsp_st_in    = res_st_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      x_ff       <= x_in;
      pval_ff    <= pval_in;
      idx_ff     <= idx_in;
      e_prev_ff  <= e_prev_in;
      v_prev_ff  <= v_prev_in;
      e1_ff      <= e1_in;
      v1_ff      <= v1_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status to the controller
   always_comb begin
      stat.func      = func_ff;
      stat.cnt_zero  = (count_ff == '0);
      stat.cnt_one   = (count_ff == CNT_W'(1));
      stat.cnt_full  = (count_ff >= CNT_W'(MAX_POINTS));
      stat.x_ge_last = (x_ff >= e_rd);
      stat.seg_hit   = (x_ff >= e_prev_ff) && (x_ff < e_rd);
      stat.scan_end  = (CNT_W'(idx_ff) == cnt_m1);
      stat.div_done  = div_done;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;
endmodule

// File: rtl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl: interpolator sequencer
// Decodes each item and steps the datapath through clear, append, last-point
// check, segment scan, multiply and divide, then hands off the result.
// ----------------------------------------------------------------------------
module tli_ctrl import tli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tli_stat_type stat,
   output tli_cmd_type  cmd
);
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_LAST_CHK  = 4'd2;
   localparam logic [3:0] S_SCAN0     = 4'd3;
   localparam logic [3:0] S_SCAN      = 4'd4;
   localparam logic [3:0] S_MUL       = 4'd5;
   localparam logic [3:0] S_DIV_START = 4'd6;
   localparam logic [3:0] S_DIV_WAIT  = 4'd7;
   localparam logic [3:0] S_EMIT      = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RSEL_ZERO;
            cmd.res_status = ST_OK;
            state_in       = S_EMIT;
            case (stat.func)
               FN_CLEAR: begin
                  cmd.clear_cnt = 1'b1;
               end
               FN_APPEND: begin
                  if (stat.cnt_full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               FN_QUERY: begin
                  if (stat.cnt_zero) begin
                     cmd.res_status = ST_EMPTY;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.addr_sel = ASEL_LAST;
                     state_in     = S_LAST_CHK;
                  end
               end
               default: begin
                  cmd.res_status = ST_OK;
               end
            endcase
         end
         // last point is on the read port now
         S_LAST_CHK: begin
            if (stat.x_ge_last) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RSEL_LAST;
               cmd.res_status = ST_ABOVE;
               state_in       = S_EMIT;
            end else if (stat.cnt_one) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RSEL_ZERO;
               cmd.res_status = ST_BELOW;
               state_in       = S_EMIT;
            end else begin
               cmd.addr_sel = ASEL_ZERO;
               state_in     = S_SCAN0;
            end
         end
         S_SCAN0: begin
            cmd.scan_init = 1'b1;
            cmd.addr_sel  = ASEL_ONE;
            state_in      = S_SCAN;
         end
         // one table entry per cycle, first matching segment wins
         S_SCAN: begin
            if (stat.seg_hit) begin
               cmd.seg_load = 1'b1;
               state_in     = S_MUL;
            end else if (stat.scan_end) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RSEL_ZERO;
               cmd.res_status = ST_BELOW;
               state_in       = S_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
               cmd.addr_sel  = ASEL_NEXT;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RSEL_QUOT;
               cmd.res_status = ST_OK;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: rtl/table_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_top: piecewise linear interpolation table
// Breakpoint table with clear, append and interpolating query.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item: func (clear, append, query), energy (Q8.16)
//   and point_value. rsp_ch returns exactly one item per request:
//   result_value and status. Both are valid/ready channels.
//   Items are handled one at a time. A query that clamps or falls below a
//   one-point table is answered without a scan. Otherwise the table memory
//   is scanned one entry per cycle from the start until a segment is found
//   or the table ends; a hit in segment k (entries k and k+1) adds the
//   multiply and a bit-serial divide. The scan through the single read
//   port and the divider set the time a query takes.
//   The response sits in an output register; a new request is taken while
//   it waits, but the next response holds off until the receiver takes it.
//   Reset empties the table at once (point count to zero); the stores need
//   no clearing pass.
// ----------------------------------------------------------------------------
module table_linear_interpolator_top import tli_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tli_req_if.sink   req_ch,
   tli_rsp_if.source rsp_ch
);
   tli_cmd_type  cmd;
   tli_stat_type stat;

   tli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tli_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_ch.func),
      .req_energy       (req_ch.energy),
      .req_point_value  (req_ch.point_value),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_status       (rsp_ch.status)
   );
endmodule

// File: rtl/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_checker: port-level checks for the interpolator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module tli_checker import tli_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [V_W-1:0]  rsp_result_value,
   input logic [ST_W-1:0] rsp_status
);
   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_status))
      else $error("stalled response changed");

   // one item in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // error statuses carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BELOW || rsp_status == ST_EMPTY ||
                    rsp_status == ST_FULL) |-> rsp_result_value == '0)
      else $error("nonzero value with error status");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind table_linear_interpolator_top tli_checker u_tli_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status)
);

// File: tb/tb_table_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_table_linear_interpolator_top: breakpoint table interpolator testbench
// Drives clear, append and query items into the block and checks every
// result against an in-bench interpolation predictor. The run has a directed
// pass over the corner cases, a large-table fill, then random table loads and
// queries under several idle and stall mixes, including a long receiver hold.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator_top import tli_pkg::*; ();

   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;   // code with no function

   localparam int unsigned HOLD_LEN     = 400;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   localparam int unsigned MAX_REPORTS  = 40;
   localparam int unsigned FILL_POINTS  = 400;
   localparam int unsigned FILL_STEP    = (1 << E_W) / FILL_POINTS;
   localparam int unsigned E_MAX        = (1 << E_W) - 1;

   typedef struct packed {
      logic [V_W-1:0]  value;
      logic [ST_W-1:0] status;
   } interp_result_type;

   // Predicts the block from its own copy of the breakpoint table and holds
   // the results still owed by the block, oldest first.
   class interp_scoreboard_type;
      logic [E_W-1:0]    energy_tab [MAX_POINTS];
      logic [V_W-1:0]    value_tab [MAX_POINTS];
      int unsigned       n_points;
      interp_result_type owed_q [$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       queries;
      int unsigned       largest;
      int unsigned       status_count [8];

      function interp_result_type interpolate(logic [E_W-1:0] x);
         interp_result_type r;
         longint unsigned   x0, x1, xq, v0, v1, num;
         r.value  = '0;
         r.status = ST_BELOW;
         if (n_points == 0) begin
            r.status = ST_EMPTY;
            return r;
         end
         if (x >= energy_tab[n_points-1]) begin
            r.value  = value_tab[n_points-1];
            r.status = ST_ABOVE;
            return r;
         end
         xq = x;
         // first segment with e[i] <= x < e[i+1]
         for (int i = 0; i + 1 < n_points; i++) begin
            x0 = energy_tab[i];
            x1 = energy_tab[i+1];
            if (xq >= x0 && xq < x1) begin
               v0       = value_tab[i];
               v1       = value_tab[i+1];
               num      = (x1 - xq) * v0 + (xq - x0) * v1;
               r.value  = V_W'(num / (x1 - x0));
               r.status = ST_OK;
               return r;
            end
         end
         return r;
      endfunction

      function void note_request(logic [FUNC_W-1:0] fn, logic [E_W-1:0] energy,
                                 logic [V_W-1:0] pval);
         interp_result_type r;
         r.value  = '0;
         r.status = ST_OK;
         case (fn)
            FN_CLEAR: n_points = 0;
            FN_APPEND: begin
               if (n_points >= MAX_POINTS) begin
                  r.status = ST_FULL;
               end else begin
                  energy_tab[n_points] = energy;
                  value_tab[n_points]  = pval;
                  n_points++;
                  if (n_points > largest) largest = n_points;
               end
            end
            FN_QUERY: begin
               r = interpolate(energy);
               queries++;
            end
            default: ;
         endcase
         status_count[r.status]++;
         owed_q.push_back(r);
      endfunction

      function void check_result(logic [V_W-1:0] value, logic [ST_W-1:0] status);
         interp_result_type r;
         checked++;
         if (owed_q.size() == 0) begin
            if (errors < MAX_REPORTS)
               $error("unexpected result item: result_value %0h status %0d", value, status);
            errors++;
            return;
         end
         r = owed_q.pop_front();
         if (value !== r.value) begin
            if (errors < MAX_REPORTS)
               $error("result_value: expected %0h, actual %0h", r.value, value);
            errors++;
         end
         if (status !== r.status) begin
            if (errors < MAX_REPORTS)
               $error("status: expected %0d, actual %0d", r.status, status);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return owed_q.size();
      endfunction

      function int unsigned wrap_up();
         if (owed_q.size() != 0) begin
            $error("%0d expected result items never arrived", owed_q.size());
            errors++;
         end
         return errors;
      endfunction
   endclass

   logic clock;
   logic reset;

   tli_req_if req_ch ();
   tli_rsp_if rsp_ch ();

   table_linear_interpolator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   interp_scoreboard_type sb = new();

   int unsigned    cycle_count;
   int unsigned    items_sent;
   int unsigned    src_idle_pct;
   int unsigned    snk_stall_pct;
   int unsigned    hold_asked;
   logic [E_W-1:0] bp_energy [$];   // energies loaded by the last table build

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   // result receiver: random stalls, plus a long hold when asked
   initial begin
      int unsigned hold_taken;
      int unsigned hold_left;
      hold_taken   = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
         end
      end
   end

   // monitor: results are checked before the same edge's request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.result_value, rsp_ch.status);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.func, req_ch.energy, req_ch.point_value);
      end
   end

   // offer one item after random idle cycles; returns at the falling edge
   // following its acceptance
   task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [E_W-1:0] energy,
                            input logic [V_W-1:0] pval);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= fn;
      req_ch.energy      <= energy;
      req_ch.point_value <= pval;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (fn != FN_UNUSED) items_sent++;
   endtask

   function automatic logic [V_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // query energy aimed at the loaded breakpoints
   function automatic logic [E_W-1:0] query_energy();
      int unsigned first, last, idx;
      first = bp_energy[0];
      last  = bp_energy[$];
      idx   = $urandom_range(0, bp_energy.size() - 1);
      case ($urandom_range(0, 9))
         0: return (first == 0) ? '0 : E_W'($urandom_range(0, first - 1));
         1: return E_W'($urandom_range(last, E_MAX));
         2: return bp_energy[idx];
         3: return $urandom_range(0, 1) ? E_W'(bp_energy[idx] + 1) : E_W'(bp_energy[idx] - 1);
         4: return E_W'($urandom_range(0, E_MAX));
         default: return E_W'($urandom_range(first, last));
      endcase
   endfunction

   // clear, then append n ascending points; narrow tables use tiny steps
   // and may repeat an energy
   task automatic load_table(input int unsigned n, input bit narrow);
      int unsigned base, step_max, e;
      bp_energy.delete();
      send_item(FN_CLEAR, E_W'($urandom_range(0, E_MAX)), rand_value());
      base     = narrow ? $urandom_range(0, E_MAX - 4 * n) : $urandom_range(0, E_MAX / 2);
      step_max = narrow ? 3 : (E_MAX - base) / n;
      e        = base;
      for (int k = 0; k < n; k++) begin
         bp_energy.push_back(E_W'(e));
         send_item(FN_APPEND, E_W'(e), rand_value());
         e += $urandom_range(narrow ? 0 : 1, step_max);
      end
   endtask

   // one more point above the current last one
   task automatic extend_table();
      int unsigned e;
      if (bp_energy[$] < E_MAX) begin
         e = $urandom_range(bp_energy[$] + 1, E_MAX);
         bp_energy.push_back(E_W'(e));
         send_item(FN_APPEND, E_W'(e), rand_value());
      end
   endtask

   task automatic random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                               input int unsigned count, input bit squeeze);
      int unsigned goal, n, pick;
      src_idle_pct  = src_pct;
      snk_stall_pct = snk_pct;
      goal          = items_sent + count;
      // receiver holds off while items keep coming, so the block backs up
      if (squeeze) begin
         hold_asked++;
         load_table(12, 1'b0);
         repeat (6) send_item(FN_QUERY, query_energy(), $urandom());
      end
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 64) : $urandom_range(1, 10);
            load_table(n, $urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 10)) send_item(FN_QUERY, query_energy(), $urandom());
            if (pick < 25) begin
               repeat ($urandom_range(1, 4)) begin
                  extend_table();
                  send_item(FN_QUERY, query_energy(), $urandom());
               end
            end
         end else begin
            // noise: any function, any order
            repeat ($urandom_range(1, 6))
               send_item(FUNC_W'($urandom_range(0, 3)), E_W'($urandom_range(0, E_MAX)),
                         rand_value());
         end
      end
   endtask

   // stimulus
   initial begin
      int unsigned e;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FN_CLEAR;
      req_ch.energy      = '0;
      req_ch.point_value = '0;
      cycle_count        = 0;
      items_sent         = 0;
      src_idle_pct       = 0;
      snk_stall_pct      = 0;
      hold_asked         = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners
      send_item(FN_QUERY,  24'h123456, 32'h0);         // empty table
      send_item(FN_CLEAR,  24'hFFFFFF, 32'hFFFFFFFF);
      send_item(FN_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF);
      send_item(FN_APPEND, 24'h000000, 32'h0);
      send_item(FN_QUERY,  24'h000000, 32'h0);         // at the only point
      send_item(FN_QUERY,  24'hFFFFFF, 32'h0);
      send_item(FN_CLEAR,  24'h0, 32'h0);
      send_item(FN_APPEND, 24'h100000, 32'hFFFFFFFF);
      send_item(FN_QUERY,  24'h0FFFFF, 32'h0);         // below a one-point table
      send_item(FN_APPEND, 24'hFFFFFF, 32'h0);
      send_item(FN_QUERY,  24'h100000, 32'h0);         // exactly on first point
      send_item(FN_QUERY,  24'h800000, 32'h0);
      send_item(FN_QUERY,  24'hFFFFFE, 32'h0);
      send_item(FN_APPEND, 24'h000010, 32'h5);         // out of order
      send_item(FN_QUERY,  24'h000008, 32'h0);         // no segment found
      send_item(FN_QUERY,  24'h200000, 32'h0);
      send_item(FN_CLEAR,  24'h0, 32'h0);
      send_item(FN_APPEND, 24'h000000, 32'hFFFFFFFF);
      send_item(FN_APPEND, 24'hFFFFFF, 32'hFFFFFFFF);
      send_item(FN_QUERY,  24'h000001, 32'h0);         // widest weighted sum
      send_item(FN_CLEAR,  24'h0, 32'h0);
      send_item(FN_APPEND, 24'h000050, 32'h7);         // repeated energy
      send_item(FN_APPEND, 24'h000050, 32'h9);
      send_item(FN_APPEND, 24'h000051, 32'h0);
      send_item(FN_QUERY,  24'h000050, 32'h0);

      // load a large table spread over the whole energy range and query it
      bp_energy.delete();
      send_item(FN_CLEAR, 24'h0, 32'h0);
      for (int i = 0; i < FILL_POINTS; i++) begin
         e = i * FILL_STEP + $urandom_range(0, FILL_STEP - 1);
         bp_energy.push_back(E_W'(e));
         send_item(FN_APPEND, E_W'(e), rand_value());
      end
      repeat (8) send_item(FN_QUERY, query_energy(), 32'h0);
      send_item(FN_QUERY, 24'hFFFFFF, 32'h0);

      // random traffic under each idle mix
      random_phase(0, 0, 270, 1'b1);
      random_phase(80, 0, 270, 1'b0);
      random_phase(0, 80, 270, 1'b0);
      random_phase(21, 21, 270, 1'b0);
      req_ch.valid <= 1'b0;
      snk_stall_pct = 0;

      // drain
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d result items over %0d queries; largest table %0d points",
               sb.checked, sb.queries, sb.largest);
      $display("Status mix: ok %0d, below %0d, clamped %0d, empty %0d, full %0d",
               sb.status_count[ST_OK], sb.status_count[ST_BELOW],
               sb.status_count[ST_ABOVE], sb.status_count[ST_EMPTY],
               sb.status_count[ST_FULL]);
      if (sb.wrap_up() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tli_pkg.sv
rtl/tli_req_if.sv
rtl/tli_rsp_if.sv
rtl/tli_ram.sv
rtl/tli_div.sv
rtl/tli_dp.sv
rtl/tli_ctrl.sv
rtl/table_linear_interpolator_top.sv
rtl/tli_checker.sv
tb/tb_table_linear_interpolator_top.sv
